/* rtl/core/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg: shared types, constants and functions of the Hamming SEC codec
// Field widths, payload structs, code geometry and the syndrome function
// used by both the encoder and the decoder.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Field widths
  localparam int DATA_W = 32;  // data word
  localparam int CODE_W = 38;  // code word, position p at bit p-1
  localparam int SYN_W  = 6;   // syndrome / error position
  localparam int CFG_W  = 6;   // data length register

  // Defaults for the top-level parameters
  localparam int MAX_DATA_BITS_DEF   = 32;
  localparam int MAX_PARITY_BITS_DEF = 6;

  // Data length after reset
  localparam logic [CFG_W-1:0] DATA_BITS_RST = CFG_W'(32);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic [DATA_W-1:0] data_word;
    logic [CODE_W-1:0] code_word;
  } hsc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic [DATA_W-1:0] data_out;
    logic [SYN_W-1:0]  error_position;
    status_t           status;
  } hsc_out_t;

  // Effective code geometry: data length m and code length n
  typedef struct packed {
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] n;
  } hsc_geom_t;

  // Code position (1-based) of the j-th data slot: the j-th position
  // that is not a power of two
  function automatic int slot_pos(input int j);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) pos = p;
        cnt++;
      end
    end
    return pos;
  endfunction

  // Positions whose index has bit k set
  function automatic logic [CODE_W-1:0] cover_mask(input int k);
    logic [CODE_W-1:0] msk;
    msk = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      msk[p-1] = ((p >> k) & 1) != 0;
    end
    return msk;
  endfunction

  // XOR of the indices of all set positions
  function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_W-1:0] w);
    logic [SYN_W-1:0] s;
    for (int k = 0; k < SYN_W; k++) begin
      s[k] = ^(w & cover_mask(k));
    end
    return s;
  endfunction

endpackage

/* rtl/core/hsc_cfg.sv */
// ----------------------------------------------------------------------------
// hsc_cfg: data length register
// Clamps the written data length and holds the resulting data length and
// code length (data plus parity count from 2^r >= m + r + 1).
// ----------------------------------------------------------------------------
module hsc_cfg
  import hsc_pkg::*;
#(
  parameter int MAX_DATA_BITS   = MAX_DATA_BITS_DEF,
  parameter int MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output hsc_geom_t        geom
);

  // Largest data length the data field can carry
  localparam int MAX_M = (MAX_DATA_BITS < DATA_W) ? MAX_DATA_BITS : DATA_W;

  hsc_geom_t geom_r;
  hsc_geom_t geom_nxt;

  // Clamp the length, then find the parity count (a few narrow steps)
  function automatic hsc_geom_t geom_of(input logic [CFG_W-1:0] v);
    hsc_geom_t g;
    int        m;
    int        r;
    m = int'(v);
    if (m < 1) m = 1;
    if (m > MAX_M) m = MAX_M;
    r = 1;
    for (int i = 1; i < MAX_PARITY_BITS; i++) begin
      if ((1 << r) < m + r + 1) r = r + 1;
    end
    g.m = CFG_W'(m);
    g.n = CFG_W'(m + r);
    return g;
  endfunction

  // Next geometry on a register write
  always_comb begin
    geom_nxt = geom_r;
    if (cfg_we) geom_nxt = geom_of(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= geom_of(DATA_BITS_RST);
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

/* rtl/core/hsc_enc.sv */
// ----------------------------------------------------------------------------
// hsc_enc: Hamming encoder
// Places the data most significant bit first into the non-power-of-two
// positions and fills the parity positions from the data syndrome.
// ----------------------------------------------------------------------------
module hsc_enc
  import hsc_pkg::*;
(
  input  hsc_geom_t         geom,
  input  logic [DATA_W-1:0] data_word,
  output logic [CODE_W-1:0] code_out,
  output logic [DATA_W-1:0] data_out
);

  logic [CFG_W-1:0]  gap;
  logic [DATA_W-1:0] data_left;
  logic [CODE_W-1:0] w_data;
  logic [SYN_W-1:0]  s;

  // Left-justify the used data bits; slot j takes bit DATA_W-1-j
  assign gap       = CFG_W'(DATA_W) - geom.m;
  assign data_left = data_word << gap;
  assign data_out  = data_word & ({DATA_W{1'b1}} >> gap);

  // Data bits into their slots, parity positions left clear
  always_comb begin
    w_data = '0;
    for (int j = 0; j < DATA_W; j++) begin
      w_data[slot_pos(j)-1] = data_left[DATA_W-1-j];
    end
  end

  // Parity bit 2^k takes syndrome bit k so the full word checks to zero
  assign s = syndrome(w_data);

  always_comb begin
    code_out = w_data;
    for (int k = 0; k < SYN_W; k++) begin
      if ((1 << k) <= CODE_W) code_out[(1 << k) - 1] = s[k];
    end
  end

endmodule

/* rtl/core/hsc_dec.sv */
// ----------------------------------------------------------------------------
// hsc_dec: Hamming decoder
// Masks the received word to the code length, computes the syndrome,
// flips the named bit when it lies inside the code, and extracts the data.
// ----------------------------------------------------------------------------
module hsc_dec
  import hsc_pkg::*;
(
  input  hsc_geom_t         geom,
  input  logic [CODE_W-1:0] code_word,
  output logic [CODE_W-1:0] code_out,
  output logic [DATA_W-1:0] data_out,
  output logic [SYN_W-1:0]  error_position,
  output status_t           status
);

  logic [CODE_W-1:0] w;
  logic [CODE_W-1:0] flip;
  logic [SYN_W-1:0]  s;
  logic [DATA_W-1:0] slots;

  // Ignore positions past the code length
  assign w = code_word & ({CODE_W{1'b1}} >> (CFG_W'(CODE_W) - geom.n));
  assign s = syndrome(w);

  // Classify the syndrome
  always_comb begin
    if (s == '0) begin
      status = ST_OK;
    end else if (s <= geom.n) begin
      status = ST_CORRECTED;
    end else begin
      status = ST_BEYOND;
    end
  end

  // Single-bit correction
  assign flip     = (status == ST_CORRECTED) ? (CODE_W'(1) << (s - SYN_W'(1))) : '0;
  assign code_out = w ^ flip;

  // Gather slots, first slot as MSB, then right-align to the data length
  always_comb begin
    for (int j = 0; j < DATA_W; j++) begin
      slots[DATA_W-1-j] = code_out[slot_pos(j)-1];
    end
  end

  assign data_out       = slots >> (CFG_W'(DATA_W) - geom.m);
  assign error_position = s;

endmodule

/* rtl/core/hamming_sec_codec.sv */
// ----------------------------------------------------------------------------
// hamming_sec_codec: Hamming single-error-correcting encoder/decoder
// Encodes data words or checks and corrects code words for a configured
// data length of 1 to 32 bits, even parity, parity bits at powers of two.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in_     | input     | in_valid / in_stall  | hsc_in_t  (opcode, words)
//   out_    | output    | out_valid / out_stall| hsc_out_t (words, syndrome)
//   cfg_    | input     | cfg_we               | cfg_data  (data length)
//
// One item per cycle sustained while out_stall is low; a transfer on in_ passes
// through the input register, one pass of XOR trees and shifts, and the result
// register before it shows on out_. out_stall holds the result register and,
// only when both registers are full, raises in_stall in the same cycle.
// Synchronous active-low reset empties both registers and sets the data
// length to 32; no clearing pass.
// ----------------------------------------------------------------------------
module hamming_sec_codec
  import hsc_pkg::*;
#(
  parameter int MAX_DATA_BITS   = MAX_DATA_BITS_DEF,
  parameter int MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  hsc_in_t          in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output hsc_out_t         out_data,
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  hsc_geom_t geom;

  logic     in_valid_r;
  logic     in_valid_nxt;
  hsc_in_t  in_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  hsc_out_t out_data_r;
  hsc_out_t result;
  logic     advance;

  logic [CODE_W-1:0] enc_code;
  logic [DATA_W-1:0] enc_data;
  logic [CODE_W-1:0] dec_code;
  logic [DATA_W-1:0] dec_data;
  logic [SYN_W-1:0]  dec_syn;
  status_t           dec_status;

  // Data length register
  hsc_cfg #(
    .MAX_DATA_BITS   (MAX_DATA_BITS),
    .MAX_PARITY_BITS (MAX_PARITY_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .geom     (geom)
  );

  hsc_enc u_enc (
    .geom      (geom),
    .data_word (in_data_r.data_word),
    .code_out  (enc_code),
    .data_out  (enc_data)
  );

  hsc_dec u_dec (
    .geom           (geom),
    .code_word      (in_data_r.code_word),
    .code_out       (dec_code),
    .data_out       (dec_data),
    .error_position (dec_syn),
    .status         (dec_status)
  );

  // Result register can load when empty or when its transfer completes
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Select the result of the requested operation
  always_comb begin
    if (in_data_r.opcode == OP_DECODE) begin
      result.code_out       = dec_code;
      result.data_out       = dec_data;
      result.error_position = dec_syn;
      result.status         = dec_status;
    end else begin
      result.code_out       = enc_code;
      result.data_out       = enc_data;
      result.error_position = '0;
      result.status         = ST_OK;
    end
  end

  // Valid flags of both stages
  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (!in_stall) in_valid_nxt = in_valid;
    if (advance) out_valid_nxt = in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (advance && in_valid_r) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/hsc_chk.sv */
// ----------------------------------------------------------------------------
// hsc_chk: port-level checker for the Hamming SEC codec
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module hsc_chk
  import hsc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input hsc_out_t out_data
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every emitted word checks clean unless the syndrome fell outside the code
  a_syn_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((syndrome(out_data.code_out) == '0) ==
                   (out_data.status != ST_BEYOND)))
    else $error("result word syndrome disagrees with status");

  // Input is only held back when a result is waiting
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hamming_sec_codec hsc_chk u_hsc_chk (.*);
